>>> rtl/tmcw_pkg.sv
package tmcw_pkg;

  // Default console geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Attribute byte after reset
  localparam logic [7:0] COLOR_RST = 8'h07;

  // Character codes with a meaning of their own
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  // Request kinds carried on in_tuser
  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Beat widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_FIN
  } tmcw_state_t;

endpackage

>>> rtl/text_mode_console_writer_unit.sv
// Channel | Dir | Signals                   | Contents
// in      | in  | in_tvalid/tready/tdata/tuser | tuser: req_type; tdata: char, row, col
// out     | out | out_tvalid/tready/tdata   | cell char, cell color, cursor row, col
// cfg     | in  | cfg_wr_en/cfg_wr_data     | text color attribute
//
// After reset a clearing pass writes every cell, with in_tready low.
// A read, print, backspace or plain newline runs through ST_EXEC and ST_FIN before out_tvalid rises:
// the store is read at the accept edge, ST_EXEC modifies and writes the cell, ST_FIN loads the
// output register; the next beat is taken back in ST_IDLE, once the item is done.
// A newline or wrap on the last row adds a scroll pass, one cell per cycle through the single
// read port and single write port of the cell store.
// One item is in flight at a time; a held result does not block the next accept, but the
// item after it waits in its last cycle until the output register is free.
module text_mode_console_writer_unit #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [tmcw_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] req_type
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] cell_char, [15:8] cell_color, [20:16] cursor_row_out, [27:21] cursor_col_out,
  // [31:28] zero
  output logic [tmcw_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [7:0]                       cfg_wr_data
);
  import tmcw_pkg::*;

  localparam int DEPTH     = ROWS * COLUMNS;
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);

  // Input beat fields
  logic [7:0] in_char;
  logic [4:0] in_row;
  logic [6:0] in_col;
  assign in_char = in_tdata[7:0];
  assign in_row  = in_tdata[12:8];
  assign in_col  = in_tdata[19:13];

  tmcw_state_t state_r, state_nxt;

  // Cell store: {attr, char}
  logic [15:0]       cell_mem [DEPTH];
  logic [15:0]       rdata_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;

  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              wp_vld_r, wp_vld_nxt;
  logic [ADDR_W-1:0] wp_addr_r, wp_addr_nxt;
  logic              wp_last_r, wp_last_nxt;

  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ADDR_W-1:0] row_base_r, row_base_nxt;
  logic [7:0]        color_r;

  logic              req_r;
  logic [7:0]        ch_r;
  logic              ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [7:0]        res_char_r, res_char_nxt;
  logic [7:0]        res_color_r, res_color_nxt;

  logic              out_vld_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic              in_fire;
  logic              out_free;
  logic              scan_more;
  logic              scroll_need;
  logic              is_nl, is_bs;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] in_addr;
  logic              in_ok;
  logic [ADDR_W-1:0] scroll_src;

  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_vld_r || out_tready;
  assign scan_more = scan_r < CNT_W'(DEPTH);
  assign is_nl     = (ch_r == CH_NEWLINE);
  assign is_bs     = (ch_r == CH_BACKSPACE);
  assign cur_addr  = row_base_r + ADDR_W'(cur_col_r);

  // Decide whether the current put runs off the last row
  assign scroll_need = (req_r == REQ_PUT) && (32'(cur_row_r) == ROWS - 1) &&
                       (is_nl || (!is_bs && (32'(cur_col_r) == COLUMNS - 1)));

  // Address of the cell the incoming beat touches
  always_comb begin
    in_ok   = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
    in_addr = cur_addr;
    if (in_tuser == REQ_READ) begin
      in_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(COLUMNS)) + ADDR_W'(in_col);
    end else if (in_char == CH_BACKSPACE) begin
      in_addr = cur_addr - ADDR_W'(1);
    end
  end

  // Scroll source: one row down, the last row reads itself
  assign scroll_src = (scan_r < CNT_W'(LAST_BASE)) ?
                      scan_r[ADDR_W-1:0] + ADDR_W'(COLUMNS) : scan_r[ADDR_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (scan_r == CNT_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_fire) state_nxt = ST_EXEC;
      ST_EXEC:   state_nxt = scroll_need ? ST_SCROLL : ST_FIN;
      ST_SCROLL: if (wp_vld_r && (wp_addr_r == ADDR_W'(DEPTH - 1))) state_nxt = ST_FIN;
      ST_FIN:    if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // Store port controls and input ready
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = {color_r, ch_r};
    mem_raddr = in_addr;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r[ADDR_W-1:0];
        mem_wdata = {8'h00, CH_SPACE};
      end
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_EXEC: begin
        if (req_r == REQ_PUT && !is_nl) begin
          if (is_bs) begin
            mem_we    = (cur_col_r != '0);
            mem_wdata = {rdata_r[15:8], CH_SPACE};
          end else begin
            mem_we = 1'b1;
          end
        end
      end
      ST_SCROLL: begin
        mem_raddr = scroll_src;
        mem_we    = wp_vld_r;
        mem_waddr = wp_addr_r;
        mem_wdata = {rdata_r[15:8], wp_last_r ? CH_SPACE : rdata_r[7:0]};
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // Cursor, scan and result next values
  always_comb begin
    cur_row_nxt   = cur_row_r;
    cur_col_nxt   = cur_col_r;
    row_base_nxt  = row_base_r;
    scan_nxt      = scan_r;
    wp_vld_nxt    = 1'b0;
    wp_addr_nxt   = scan_r[ADDR_W-1:0];
    wp_last_nxt   = scan_r >= CNT_W'(LAST_BASE);
    res_char_nxt  = res_char_r;
    res_color_nxt = res_color_r;
    unique case (state_r)
      ST_CLEAR: begin
        scan_nxt = (scan_r == CNT_W'(DEPTH - 1)) ? '0 : scan_r + CNT_W'(1);
      end
      ST_EXEC: begin
        res_char_nxt  = (req_r == REQ_READ && ok_r) ? rdata_r[7:0] : 8'h00;
        res_color_nxt = (req_r == REQ_READ && ok_r) ? rdata_r[15:8] : 8'h00;
        scan_nxt      = '0;
        if (req_r == REQ_PUT) begin
          if (is_bs) begin
            if (cur_col_r != '0) cur_col_nxt = cur_col_r - COL_W'(1);
          end else if (is_nl || (32'(cur_col_r) == COLUMNS - 1)) begin
            // Advance to column 0 of the next row, or stay on the last one
            cur_col_nxt = '0;
            if (32'(cur_row_r) != ROWS - 1) begin
              cur_row_nxt  = cur_row_r + ROW_W'(1);
              row_base_nxt = row_base_r + ADDR_W'(COLUMNS);
            end
          end else begin
            cur_col_nxt = cur_col_r + COL_W'(1);
          end
        end
      end
      ST_SCROLL: begin
        wp_vld_nxt = scan_more;
        if (scan_more) scan_nxt = scan_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Cell store, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= cell_mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      scan_r     <= '0;
      wp_vld_r   <= 1'b0;
      cur_row_r  <= '0;
      cur_col_r  <= '0;
      row_base_r <= '0;
      color_r    <= COLOR_RST;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_r     <= scan_nxt;
      wp_vld_r   <= wp_vld_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      row_base_r <= row_base_nxt;
      if (cfg_wr_en) color_r <= cfg_wr_data;
      if (state_r == ST_FIN && out_free) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    wp_addr_r   <= wp_addr_nxt;
    wp_last_r   <= wp_last_nxt;
    res_char_r  <= res_char_nxt;
    res_color_r <= res_color_nxt;
    if (in_fire) begin
      req_r  <= in_tuser;
      ch_r   <= in_char;
      ok_r   <= in_ok;
      addr_r <= in_addr;
    end
    if (state_r == ST_FIN && out_free) begin
      out_data_r <= {4'h0, 7'(cur_col_r), 5'(cur_row_r), res_color_r, res_char_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/tmcw_chk.sv
module tmcw_chk #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tmcw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import tmcw_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // Keep the reported cursor inside the console
  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (32'(out_tdata[27:21]) < COLUMNS) && (32'(out_tdata[20:16]) < ROWS))
    else $error("cursor reported outside the console");

  // Take one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in flight");

  // Block input during the clearing pass after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("channel active right after reset");

endmodule

bind text_mode_console_writer_unit tmcw_chk #(
  .COLUMNS(COLUMNS),
  .ROWS(ROWS)
) u_tmcw_chk (
  .clk(clk),
  .rst_n(rst_n),
  .in_tvalid(in_tvalid),
  .in_tready(in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata(out_tdata)
);

>>> test/tmcw_console_checker.sv
`timescale 1ns / 1ps

module tmcw_console_checker #(
  parameter int COLUMNS = tmcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tmcw_pkg::DEF_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
  input  logic [tmcw_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] req_type
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [7:0] cell_char, [15:8] cell_color, [20:16] cursor_row_out, [27:21] cursor_col_out
  input  logic [tmcw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [7:0]                      cfg_wr_data,
  output int                              n_fail,
  output int                              n_pending
);
  import tmcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct {
    logic [7:0] chr;
    logic [7:0] color;
    logic [4:0] row;
    logic [6:0] col;
  } cell_beat_t;

  // Shadow copy of the console
  logic [7:0] shadow_char [CELLS];
  logic [7:0] shadow_attr [CELLS];
  int         cur_row;
  int         cur_col;
  logic [7:0] attr_reg;
  cell_beat_t cell_beat_q [$];

  // Move to the next line, scrolling text and colors up past the last row
  function automatic void advance_line();
    if (cur_row + 1 >= ROWS) begin
      for (int i = 0; i < CELLS - COLUMNS; i++) begin
        shadow_char[i] = shadow_char[i + COLUMNS];
        shadow_attr[i] = shadow_attr[i + COLUMNS];
      end
      for (int c = 0; c < COLUMNS; c++) begin
        shadow_char[CELLS - COLUMNS + c] = CH_SPACE;
      end
      cur_row = ROWS - 1;
    end else begin
      cur_row++;
    end
    cur_col = 0;
  endfunction

  // Apply one request to the shadow console and build the beat it returns
  function automatic cell_beat_t predict_console(input logic req, input logic [7:0] ch,
                                                 input logic [4:0] rr, input logic [6:0] rc);
    cell_beat_t res;
    int         r;
    int         c;
    r = rr;
    c = rc;
    res.chr   = 8'h00;
    res.color = 8'h00;
    if (req == REQ_READ) begin
      if (r < ROWS && c < COLUMNS) begin
        res.chr   = shadow_char[r * COLUMNS + c];
        res.color = shadow_attr[r * COLUMNS + c];
      end
    end else if (ch == CH_NEWLINE) begin
      advance_line();
    end else if (ch == CH_BACKSPACE) begin
      // a backspace at column zero leaves everything alone
      if (cur_col > 0) begin
        cur_col--;
        shadow_char[cur_row * COLUMNS + cur_col] = CH_SPACE;
      end
    end else begin
      shadow_char[cur_row * COLUMNS + cur_col] = ch;
      shadow_attr[cur_row * COLUMNS + cur_col] = attr_reg;
      cur_col++;
      if (cur_col >= COLUMNS) advance_line();
    end
    res.row = cur_row[4:0];
    res.col = cur_col[6:0];
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Track reset, register writes and beats on both channels
  always @(posedge clk) begin : watch
    cell_beat_t want;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        shadow_char[i] = CH_SPACE;
        shadow_attr[i] = 8'h00;
      end
      cur_row  = 0;
      cur_col  = 0;
      attr_reg = COLOR_RST;
      cell_beat_q.delete();
      n_fail   = 0;
    end else begin
      // compare a result beat with the oldest prediction
      if (out_tvalid && out_tready) begin
        if (cell_beat_q.size() == 0) begin
          $error("result beat 0x%0h with no prediction waiting", out_tdata);
          n_fail++;
        end else begin
          want = cell_beat_q.pop_front();
          check_field("cell_char", want.chr, out_tdata[7:0]);
          check_field("cell_color", want.color, out_tdata[15:8]);
          check_field("cursor_row_out", {3'b000, want.row}, {3'b000, out_tdata[20:16]});
          check_field("cursor_col_out", {1'b0, want.col}, {1'b0, out_tdata[27:21]});
        end
      end
      if (cfg_wr_en) attr_reg = cfg_wr_data;
      // predict an accepted request beat
      if (in_tvalid && in_tready) begin
        cell_beat_q.push_back(predict_console(in_tuser, in_tdata[7:0], in_tdata[12:8],
                                              in_tdata[19:13]));
      end
    end
    n_pending = cell_beat_q.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tmcw_pkg::*;

  localparam int COLUMNS    = DEF_COLUMNS;
  localparam int ROWS       = DEF_ROWS;
  localparam int RAND_ITEMS = 1400;
  localparam int PHASES     = 6;
  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = REQ_PUT;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [7:0]            cfg_wr_data = 8'h00;

  int   n_fail;
  int   n_pending;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   beats_sent = 0;
  logic hold_go = 1'b0;
  logic hold_done = 1'b0;

  text_mode_console_writer_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tmcw_console_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .n_fail      (n_fail),
    .n_pending   (n_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #200_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Drive out_tready: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_go && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done <= 1'b1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Offer one request beat; called and returns at a falling edge
  task automatic push_beat(input logic req, input logic [7:0] ch, input logic [4:0] rr,
                           input logic [6:0] rc);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {4'b0000, rc, rr, ch};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic put_char(input logic [7:0] ch);
    push_beat(REQ_PUT, ch, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
    push_beat(REQ_READ, 8'($urandom_range(0, 255)), rr, rc);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_color(input logic [7:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    repeat (2) @(negedge clk);
  endtask

  initial begin : stimulus
    int phase;
    int pick;
    int n;
    int r;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: corners of the store, each operation, reset color
    read_cell(5'd0, 7'd0);
    put_char(CH_BACKSPACE);
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'd31, 7'd127);
    read_cell(5'd0, 7'(COLUMNS));
    put_char(8'hFF);
    put_char(8'h00);
    put_char(8'h41);
    put_char(CH_BACKSPACE);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
    put_char(CH_NEWLINE);
    drain_results();
    write_color(8'hFF);
    put_char(8'h7F);
    put_char(8'h55);
    read_cell(5'd1, 7'd0);
    drain_results();
    write_color(8'h00);
    put_char(8'h80);
    put_char(8'hAA);
    read_cell(5'd1, 7'd1);
    read_cell(5'd1, 7'd2);

    // Random: mostly text runs with newlines, plus reads that look back at the store
    beats_sent = 0;
    phase = -1;
    while (beats_sent < RAND_ITEMS) begin
      if (beats_sent * PHASES / RAND_ITEMS != phase) begin
        phase = beats_sent * PHASES / RAND_ITEMS;
        drain_results();
        write_color(8'($urandom_range(0, 255)));
        case (phase)
          0, 1: begin
            send_idle_pct = 23;
            recv_idle_pct <= 57;
          end
          2, 3: begin
            send_idle_pct = 57;
            recv_idle_pct <= 23;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct <= 0;
          end
        endcase
        if (phase == 1) hold_go <= 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // print a run close to a full line, so the cursor usually wraps
        n = $urandom_range(COLUMNS - 3, COLUMNS + 3);
        repeat (n) put_char(8'($urandom_range(8'h20, 8'h7E)));
      end else if (pick < 9) begin
        n = $urandom_range(2, 8);
        repeat (n) put_char(CH_NEWLINE);
      end else if (pick < 15) begin
        // sweep part of one row
        r = $urandom_range(0, ROWS - 1);
        n = $urandom_range(0, COLUMNS - 12);
        for (int c = n; c < n + $urandom_range(4, 12); c++) read_cell(5'(r), 7'(c));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          put_char(8'($urandom_range(0, 255)));
        end else if (pick < 53) begin
          put_char(CH_NEWLINE);
        end else if (pick < 63) begin
          put_char(CH_BACKSPACE);
        end else if (pick < 90) begin
          read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
        end else begin
          read_cell(5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
        end
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (n_fail == 0 && n_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
